>>> hdl/sbq_pkg.sv
// Package: widths, types and codes for the saturating biquad IIR filter.
`timescale 1ns / 1ps

package sbq_pkg;

   localparam int ORDER          = 2;
   localparam int MAX_ORDER      = 2;
   localparam int SAMPLE_BITS    = 16;
   localparam int COEF_FRAC_BITS = 24;
   localparam int COEF_W         = 32;
   localparam int LIMIT_W        = 16;
   localparam int CSR_DATA_W     = 32;
   localparam int CSR_INDEX_W    = 3;
   // five products of COEF_W x SAMPLE_BITS plus rounding bias
   localparam int ACC_W          = COEF_W + SAMPLE_BITS + 3;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [COEF_W-1:0]      coef_type;
   typedef logic signed [LIMIT_W-1:0]     limit_type;
   typedef logic signed [ACC_W-1:0]       acc_type;
   typedef sample_type                    hist_type [MAX_ORDER];

   typedef struct packed {
      coef_type  b0;
      coef_type  b1;
      coef_type  b2;
      coef_type  a1;
      coef_type  a2;
      limit_type out_min;
      limit_type out_max;
   } coef_set_type;

   localparam logic OP_FILTER = 1'b0;
   localparam logic OP_PRESET = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_B0      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_B1      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_B2      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_A1      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_A2      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUT_MIN = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUT_MAX = 3'd6;

   localparam coef_type  RESET_B0      = coef_type'(64'sd16777216);
   localparam limit_type RESET_OUT_MIN = limit_type'(-64'sd32768);
   localparam limit_type RESET_OUT_MAX = limit_type'(64'sd32767);

endpackage

>>> hdl/sbq_datapath.sv
// Filter datapath: multiply-accumulate, round, shift and clamp of one sample.
`timescale 1ns / 1ps

module sbq_datapath
   import sbq_pkg::*;
(
   input  coef_set_type coefs,
   input  sample_type   sample,
   input  hist_type     u_hist,
   input  hist_type     y_hist,
   output sample_type   y_out
);

   localparam acc_type ROUND_BIAS = acc_type'(64'd1 << (COEF_FRAC_BITS - 1));
   localparam acc_type SMAX =
      acc_type'({{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}});
   localparam acc_type SMIN = ~SMAX;

   coef_type b_tap [MAX_ORDER];
   coef_type a_tap [MAX_ORDER];
   acc_type  acc;
   acc_type  y_full;
   acc_type  lim_lo;
   acc_type  lim_hi;
   acc_type  y_lim;
   acc_type  y_sat;

   assign b_tap[0] = coefs.b1;
   assign b_tap[1] = coefs.b2;
   assign a_tap[0] = coefs.a1;
   assign a_tap[1] = coefs.a2;

   always_comb begin
      acc = acc_type'(coefs.b0) * acc_type'(sample);
      for (int k = 0; k < ORDER; k++) begin
         acc = acc + acc_type'(b_tap[k]) * acc_type'(u_hist[k]);
         acc = acc - acc_type'(a_tap[k]) * acc_type'(y_hist[k]);
      end
      acc = acc + ROUND_BIAS;
   end

   assign y_full = acc >>> COEF_FRAC_BITS;
   assign lim_lo = acc_type'(coefs.out_min);
   assign lim_hi = acc_type'(coefs.out_max);

   // crossed limits give out_max above out_max, else out_min
   always_comb begin
      if (y_full > lim_hi) begin
         y_lim = lim_hi;
      end else if (y_full < lim_lo) begin
         y_lim = lim_lo;
      end else begin
         y_lim = y_full;
      end
      if (y_lim > SMAX) begin
         y_sat = SMAX;
      end else if (y_lim < SMIN) begin
         y_sat = SMIN;
      end else begin
         y_sat = y_lim;
      end
   end

   assign y_out = y_sat[SAMPLE_BITS-1:0];

endmodule

>>> hdl/saturating_biquad_iir_filter.sv
// Top level: saturating direct-form-I biquad IIR filter with register port.
`timescale 1ns / 1ps
//
// Usage:
//   req_* carries one beat per sample: req_op selects filter or preset,
//   req_sample is the input sample (or input-history fill value on preset),
//   req_preset_output is the output-history fill value on preset.
//   rsp_* returns one beat per request: the clamped filter output, or the
//   preset value echoed unchanged.
//   csr_* writes coefficients and clamp limits; index 7 is ignored. Write
//   only while no request is in flight.
// Timing:
//   A beat accepted into the input register is computed and written to the
//   result register when it advances, which sets rsp_valid. One beat per
//   cycle is sustained while the result is not stalled; the limit is the
//   combinational path through the five multipliers, the adder and the clamp,
//   which also closes the output-history feedback loop.
// Reset: synchronous, active high. Coefficients return to a pass-through
//   filter (b0 = 1.0), limits to the full sample range, histories to zero.
// Stall: a stalled result holds; the input register holds one more beat,
//   after which req_stall is raised until the result is taken.

module saturating_biquad_iir_filter
   import sbq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_op,
   input  sample_type             req_sample,
   input  sample_type             req_preset_output,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sample_type             rsp_filtered,
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   coef_set_type coefs_ff, coefs_in;

   logic       s1_valid_ff, s1_valid_in;
   logic       s1_op_ff;
   sample_type s1_sample_ff;
   sample_type s1_preset_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   sample_type rsp_filtered_ff, rsp_filtered_in;

   hist_type   u_hist_ff, u_hist_in;
   hist_type   y_hist_ff, y_hist_in;

   sample_type y_new;
   logic       req_accept;
   logic       advance;

   assign advance    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   // register file
   always_comb begin
      coefs_in = coefs_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_B0:      coefs_in.b0      = coef_type'(csr_wdata);
            CSR_B1:      coefs_in.b1      = coef_type'(csr_wdata);
            CSR_B2:      coefs_in.b2      = coef_type'(csr_wdata);
            CSR_A1:      coefs_in.a1      = coef_type'(csr_wdata);
            CSR_A2:      coefs_in.a2      = coef_type'(csr_wdata);
            CSR_OUT_MIN: coefs_in.out_min = limit_type'(csr_wdata[LIMIT_W-1:0]);
            CSR_OUT_MAX: coefs_in.out_max = limit_type'(csr_wdata[LIMIT_W-1:0]);
            default:     coefs_in = coefs_ff;
         endcase
      end
   end

   sbq_datapath u_datapath (
      .coefs  (coefs_ff),
      .sample (s1_sample_ff),
      .u_hist (u_hist_ff),
      .y_hist (y_hist_ff),
      .y_out  (y_new)
   );

   // history update and result select
   always_comb begin
      u_hist_in       = u_hist_ff;
      y_hist_in       = y_hist_ff;
      rsp_filtered_in = rsp_filtered_ff;
      if (advance) begin
         if (s1_op_ff == OP_PRESET) begin
            for (int k = 0; k < ORDER; k++) begin
               u_hist_in[k] = s1_sample_ff;
               y_hist_in[k] = s1_preset_ff;
            end
            rsp_filtered_in = s1_preset_ff;
         end else begin
            for (int k = ORDER - 1; k > 0; k--) begin
               u_hist_in[k] = u_hist_ff[k-1];
               y_hist_in[k] = y_hist_ff[k-1];
            end
            u_hist_in[0]    = s1_sample_ff;
            y_hist_in[0]    = y_new;
            rsp_filtered_in = y_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coefs_ff.b0      <= RESET_B0;
         coefs_ff.b1      <= '0;
         coefs_ff.b2      <= '0;
         coefs_ff.a1      <= '0;
         coefs_ff.a2      <= '0;
         coefs_ff.out_min <= RESET_OUT_MIN;
         coefs_ff.out_max <= RESET_OUT_MAX;
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         for (int k = 0; k < MAX_ORDER; k++) begin
            u_hist_ff[k] <= '0;
            y_hist_ff[k] <= '0;
         end
      end else begin
         coefs_ff     <= coefs_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         u_hist_ff    <= u_hist_in;
         y_hist_ff    <= y_hist_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff     <= req_op;
         s1_sample_ff <= req_sample;
         s1_preset_ff <= req_preset_output;
      end
      rsp_filtered_ff <= rsp_filtered_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;

`ifndef SYNTHESIS
   // newest output history always matches the beat just produced
   assert property (@(posedge clock) disable iff (reset)
      advance |=> (y_hist_ff[0] == rsp_filtered))
      else $error("output history does not match delivered beat");

   // preset value is echoed unchanged
   assert property (@(posedge clock) disable iff (reset)
      (advance && s1_op_ff == OP_PRESET) |=> (rsp_filtered == $past(s1_preset_ff)))
      else $error("preset beat not echoed");

   // filtered output respects ordered clamp limits
   assert property (@(posedge clock) disable iff (reset)
      (advance && s1_op_ff == OP_FILTER && coefs_ff.out_min <= coefs_ff.out_max)
      |=> (acc_type'(rsp_filtered) >= acc_type'($past(coefs_ff.out_min))
           && acc_type'(rsp_filtered) <= acc_type'($past(coefs_ff.out_max))))
      else $error("filtered beat outside clamp limits");

   // a new beat is only taken when the input register is free or draining
   assert property (@(posedge clock) disable iff (reset)
      req_accept |-> (!s1_valid_ff || advance))
      else $error("input register overrun");
`endif

endmodule
